// ===== hw/rtl/mcp_pkg.sv =====
// ----------------------------------------------------------------------------
// mcp_pkg
// Shared types, constants and helpers of the midpoint circle point generator.
// ----------------------------------------------------------------------------
package mcp_pkg;

  localparam int RADIUS_BITS = 10;
  localparam int PT_W        = 11;
  localparam int DEC_W       = RADIUS_BITS + 4;
  localparam int NUM_SYM     = 8;
  localparam int SEL_W       = 3;
  localparam int RADIUS_MAX  = (1 << RADIUS_BITS) - 1;

  // Decision variable constants of the midpoint scheme.
  localparam int DEC_START   = 3;
  localparam int DEC_INC_NEG = 6;
  localparam int DEC_INC_POS = 10;

  // Item modes.
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_NEXT  = 1'b1;

  // The eight symmetric points, in emission order.
  localparam logic [SEL_W-1:0] SYM_PX_PY = 3'd0;
  localparam logic [SEL_W-1:0] SYM_NX_PY = 3'd1;
  localparam logic [SEL_W-1:0] SYM_PX_NY = 3'd2;
  localparam logic [SEL_W-1:0] SYM_NX_NY = 3'd3;
  localparam logic [SEL_W-1:0] SYM_PY_PX = 3'd4;
  localparam logic [SEL_W-1:0] SYM_NY_PX = 3'd5;
  localparam logic [SEL_W-1:0] SYM_PY_NX = 3'd6;
  localparam logic [SEL_W-1:0] SYM_NY_NX = 3'd7;

  typedef struct packed {
    logic                   emit;
    logic [RADIUS_BITS-1:0] x;
    logic [RADIUS_BITS-1:0] y;
    logic [NUM_SYM-1:0]     mask;
    logic                   done;
  } iter_t;

  function automatic logic signed [31:0] cand_x(input logic [SEL_W-1:0] sel,
                                                 input logic [RADIUS_BITS-1:0] x,
                                                 input logic [RADIUS_BITS-1:0] y);
    logic signed [31:0] xi;
    logic signed [31:0] yi;
    logic signed [31:0] r;
    xi = 32'(x);
    yi = 32'(y);
    case (sel)
      SYM_PX_PY: r = xi;
      SYM_NX_PY: r = -xi;
      SYM_PX_NY: r = xi;
      SYM_NX_NY: r = -xi;
      SYM_PY_PX: r = yi;
      SYM_NY_PX: r = -yi;
      SYM_PY_NX: r = yi;
      SYM_NY_NX: r = -yi;
      default:   r = xi;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] cand_y(input logic [SEL_W-1:0] sel,
                                                 input logic [RADIUS_BITS-1:0] x,
                                                 input logic [RADIUS_BITS-1:0] y);
    logic signed [31:0] xi;
    logic signed [31:0] yi;
    logic signed [31:0] r;
    xi = 32'(x);
    yi = 32'(y);
    case (sel)
      SYM_PX_PY: r = yi;
      SYM_NX_PY: r = yi;
      SYM_PX_NY: r = -yi;
      SYM_NX_NY: r = -yi;
      SYM_PY_PX: r = xi;
      SYM_NY_PX: r = xi;
      SYM_PY_NX: r = -xi;
      SYM_NY_NX: r = -xi;
      default:   r = yi;
    endcase
    return r;
  endfunction

  // A point is kept only if no earlier point of the same iteration equals it.
  function automatic logic [NUM_SYM-1:0] dedup_mask(input logic [RADIUS_BITS-1:0] x,
                                                     input logic [RADIUS_BITS-1:0] y);
    logic [NUM_SYM-1:0] m;
    logic signed [31:0] xa;
    logic signed [31:0] ya;
    logic signed [31:0] xb;
    logic signed [31:0] yb;
    m = '1;
    for (int i = 1; i < NUM_SYM; i++) begin
      xa = cand_x(SEL_W'(i), x, y);
      ya = cand_y(SEL_W'(i), x, y);
      for (int j = 0; j < i; j++) begin
        xb = cand_x(SEL_W'(j), x, y);
        yb = cand_y(SEL_W'(j), x, y);
        if (xa == xb && ya == yb) begin
          m[i] = 1'b0;
        end
      end
    end
    return m;
  endfunction

endpackage

// ===== hw/rtl/mcp_in_if.sv =====
// ----------------------------------------------------------------------------
// mcp_in_if
// Item channel into the circle point generator: mode and radius.
// ----------------------------------------------------------------------------
interface mcp_in_if import mcp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   mode;
  logic signed [PT_W-1:0] radius;

  modport source (output valid, output mode, output radius, input ready);
  modport sink   (input valid, input mode, input radius, output ready);
endinterface

// ===== hw/rtl/mcp_out_if.sv =====
// ----------------------------------------------------------------------------
// mcp_out_if
// Point channel out of the circle point generator.
// ----------------------------------------------------------------------------
interface mcp_out_if import mcp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [PT_W-1:0] point_x;
  logic signed [PT_W-1:0] point_y;
  logic                   last_of_step;
  logic                   circle_done;

  modport source (output valid, output point_x, output point_y, output last_of_step,
                  output circle_done, input ready);
  modport sink   (input valid, input point_x, input point_y, input last_of_step,
                  input circle_done, output ready);
endinterface

// ===== hw/rtl/mcp_iter.sv =====
// ----------------------------------------------------------------------------
// mcp_iter
// Circle state and one midpoint iteration: works out the points of the
// iteration for the offered item and advances the state when it is taken.
// ----------------------------------------------------------------------------
module mcp_iter import mcp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic                   mode,
  input  logic signed [PT_W-1:0] radius,
  output iter_t                  iter
);

  logic [RADIUS_BITS-1:0]  step_x;
  logic [RADIUS_BITS-1:0]  step_y;
  logic signed [DEC_W-1:0] decision;
  logic                    active;

  logic [RADIUS_BITS-1:0]  step_x_next;
  logic [RADIUS_BITS-1:0]  step_y_next;
  logic signed [DEC_W-1:0] decision_next;

  logic [PT_W-2:0]         raw;
  logic [RADIUS_BITS-1:0]  r;
  logic [RADIUS_BITS-1:0]  x_src;
  logic [RADIUS_BITS-1:0]  y_src;
  logic signed [31:0]      xi;
  logic signed [31:0]      yi;
  logic signed [31:0]      di;
  logic signed [31:0]      dn;
  logic signed [31:0]      xn;
  logic signed [31:0]      yn;
  logic                    start;

  always_comb begin
    start = (mode == MODE_START);
    raw   = radius[PT_W-2:0];
    if (radius[PT_W-1]) begin
      r = '0;
    end else if (32'(raw) > RADIUS_MAX) begin
      r = RADIUS_MAX[RADIUS_BITS-1:0];
    end else begin
      r = RADIUS_BITS'(raw);
    end

    x_src = start ? '0 : step_x;
    y_src = start ? r  : step_y;
    xi    = 32'(x_src);
    yi    = 32'(y_src);
    di    = start ? (DEC_START - 2 * 32'(r)) : 32'(decision);

    if (di < 0) begin
      dn = di + 4 * xi + DEC_INC_NEG;
      yn = yi;
    end else begin
      dn = di + 4 * (xi - yi) + DEC_INC_POS;
      yn = yi - 1;
    end
    xn = xi + 1;

    step_x_next   = xn[RADIUS_BITS-1:0];
    step_y_next   = (yn < 0) ? '0 : yn[RADIUS_BITS-1:0];
    decision_next = dn[DEC_W-1:0];

    iter.emit = start || active;
    iter.x    = x_src;
    iter.y    = y_src;
    iter.mask = dedup_mask(x_src, y_src);
    iter.done = (xn > yn);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_x   <= '0;
      step_y   <= '0;
      decision <= '0;
      active   <= 1'b0;
    end else if (accept && iter.emit) begin
      step_x   <= step_x_next;
      step_y   <= step_y_next;
      decision <= decision_next;
      active   <= !iter.done;
    end
  end

endmodule

// ===== hw/rtl/midpoint_circle_points_top.sv =====
// ----------------------------------------------------------------------------
// midpoint_circle_points_top
// Midpoint circle border generator: one iteration per item, up to eight
// symmetric points per iteration, duplicates within an iteration dropped.
//
//   channel  dir  payload                                          role
//   items    in   mode, radius                                     start / next
//   points   out  point_x, point_y, last_of_step, circle_done      border points
//
// An accepted item is worked out in the cycle it is taken and held in the
// iteration register; its points (one to eight) then leave one per cycle
// through the output register while points are not stalled.
// A new item is taken in the same cycle as the last point of the previous one.
// A next item with no circle in progress gives no points.
// Reset clears the circle state and both valid flags; stalls on points hold
// the output register and, through it, the item channel.
// ----------------------------------------------------------------------------
module midpoint_circle_points_top import mcp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  mcp_in_if.sink    items,
  mcp_out_if.source points
);

  iter_t                  iter;
  logic                   accept;

  logic                   cur_valid;
  logic [RADIUS_BITS-1:0] cur_x;
  logic [RADIUS_BITS-1:0] cur_y;
  logic [NUM_SYM-1:0]     cur_mask;
  logic                   cur_done;

  logic                   out_load;
  logic                   cur_fire;
  logic                   cur_last;
  logic [SEL_W-1:0]       sel;
  logic [NUM_SYM-1:0]     sel_hot;
  logic [NUM_SYM-1:0]     mask_left;
  logic signed [31:0]     px;
  logic signed [31:0]     py;

  mcp_iter u_iter (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .mode   (items.mode),
    .radius (items.radius),
    .iter   (iter)
  );

  // Lowest remaining point of the held iteration goes out next.
  always_comb begin
    sel     = '0;
    sel_hot = '0;
    for (int i = NUM_SYM - 1; i >= 0; i--) begin
      if (cur_mask[i]) begin
        sel     = SEL_W'(i);
        sel_hot = NUM_SYM'(1) << i;
      end
    end
    mask_left = cur_mask & ~sel_hot;
    px        = cand_x(sel, cur_x, cur_y);
    py        = cand_y(sel, cur_x, cur_y);
  end

  assign out_load     = !points.valid || points.ready;
  assign cur_fire     = out_load && cur_valid;
  assign cur_last     = cur_fire && (mask_left == '0);
  assign items.ready  = !cur_valid || cur_last;
  assign accept       = items.valid && items.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (accept && iter.emit) begin
      cur_valid <= 1'b1;
    end else if (cur_last) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && iter.emit) begin
      cur_x    <= iter.x;
      cur_y    <= iter.y;
      cur_mask <= iter.mask;
      cur_done <= iter.done;
    end else if (cur_fire) begin
      cur_mask <= mask_left;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      points.valid <= 1'b0;
    end else if (out_load) begin
      points.valid <= cur_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cur_fire) begin
      points.point_x      <= px[PT_W-1:0];
      points.point_y      <= py[PT_W-1:0];
      points.last_of_step <= (mask_left == '0);
      points.circle_done  <= cur_done;
    end
  end

endmodule
